FILE: hw/rtl/lzssdec_pkg.sv
// Shared types and constants of the LZSS window decompressor.
package lzssdec_pkg;

    localparam int POS_BITS_DEF  = 8;
    localparam int LEN_BITS_DEF  = 4;
    localparam int LOOKAHEAD_DEF = 1;

    // command fields sized for the largest window and length code
    localparam int ARG_W = 16;
    localparam int LEN_W = 8;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [1:0] CMD_LIT  = 2'd0;
    localparam logic [1:0] CMD_COPY = 2'd1;
    localparam logic [1:0] CMD_STAT = 2'd2;

    localparam logic [1:0] STS_RUN   = 2'd0;
    localparam logic [1:0] STS_DONE  = 2'd1;
    localparam logic [1:0] STS_SHORT = 2'd2;
    localparam logic [1:0] STS_BAD   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic [1:0] status;
        logic       run_last;
    } out_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ARG_W-1:0] arg;
        logic [LEN_W-1:0] len;
        logic [1:0]       code;
        logic             last;
        logic             restart;
    } cmd_t;

endpackage

FILE: hw/rtl/lzssdec_front.sv
// Front end: takes input beats, parses tokens, checks the limit, issues commands.
module lzssdec_front #(
    parameter int POS_BITS = lzssdec_pkg::POS_BITS_DEF,
    parameter int LEN_BITS = lzssdec_pkg::LEN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lzssdec_pkg::in_t    in_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    output logic                q_push,
    output lzssdec_pkg::cmd_t   q_wcmd,
    input  logic                q_full
);
    import lzssdec_pkg::*;

    localparam int BUF_W = ((POS_BITS > 8) ? POS_BITS : 8) + 7;
    localparam int CNT_W = $clog2(BUF_W + 1);

    localparam logic [1:0] FS_IDLE  = 2'd0;
    localparam logic [1:0] FS_PARSE = 2'd1;
    localparam logic [1:0] FS_DRAIN = 2'd2;
    localparam logic [1:0] FS_STAT  = 2'd3;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT  = 2'd1;
    localparam logic [1:0] PH_POS  = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [BUF_W-1:0]    bit_buf_reg, bit_buf_next;
    logic [CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [1:0]          phase_reg, phase_next;
    logic [POS_BITS-1:0] match_pos_reg, match_pos_next;
    logic [31:0]         produced_reg, produced_next;
    logic [31:0]         limit_reg, limit_next;
    logic                finished_reg, finished_next;
    logic [1:0]          end_code_reg, end_code_next;
    logic                item_last_reg, item_last_next;
    logic                was_fin_reg, was_fin_next;
    logic                hold_vld_reg, hold_vld_next;
    cmd_t                hold_cmd_reg, hold_cmd_next;
    logic                stat_reg, stat_next;
    logic [1:0]          scode_reg, scode_next;

    logic [CNT_W-1:0]    need;
    logic                have;
    logic [CNT_W-1:0]    shamt;
    logic [BUF_W-1:0]    field;
    logic                at_limit;
    logic [31:0]         room;
    logic [LEN_BITS-1:0] len_code;
    logic [LEN_BITS:0]   len_full;
    logic                copy_bad;

    logic [1:0]          s_phase;
    logic [CNT_W-1:0]    s_cnt;
    logic [POS_BITS-1:0] s_mpos;
    logic [31:0]         s_prod;
    logic                s_fin;
    logic [1:0]          s_code;
    logic                s_end;
    logic                s_gen;
    cmd_t                s_cmd;
    logic                stat_need;
    logic [1:0]          stat_code;

    assign in_ready = (state_reg == FS_IDLE);

    // one parsing step
    always_comb
    begin
        unique case (phase_reg)
            PH_FLAG: need = CNT_W'(1);
            PH_LIT:  need = CNT_W'(8);
            PH_POS:  need = CNT_W'(POS_BITS);
            PH_LEN:  need = CNT_W'(LEN_BITS);
        endcase
        have     = (bit_cnt_reg >= need);
        shamt    = bit_cnt_reg - need;
        field    = bit_buf_reg >> shamt;
        at_limit = (produced_reg >= limit_reg);
        room     = limit_reg - produced_reg;
        len_code = field[LEN_BITS-1:0];
        len_full = {1'b0, len_code} + (LEN_BITS + 1)'(2);
        copy_bad = at_limit || (room < 32'(len_full));

        s_phase = phase_reg;
        s_cnt   = bit_cnt_reg;
        s_mpos  = match_pos_reg;
        s_prod  = produced_reg;
        s_fin   = finished_reg;
        s_code  = end_code_reg;
        s_end   = 1'b0;
        s_gen   = 1'b0;
        s_cmd   = '0;

        if (finished_reg)
        begin
            s_end = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (at_limit)
                    begin
                        s_fin  = 1'b1;
                        s_code = STS_DONE;
                        s_end  = 1'b1;
                    end
                    else if (!have)
                    begin
                        s_end = 1'b1;
                    end
                    else
                    begin
                        s_cnt   = shamt;
                        s_phase = field[0] ? PH_LIT : PH_POS;
                    end
                end
                PH_LIT:
                begin
                    if (!have)
                    begin
                        s_end = 1'b1;
                    end
                    else
                    begin
                        s_cnt = shamt;
                        if (at_limit)
                        begin
                            s_fin  = 1'b1;
                            s_code = STS_BAD;
                            s_end  = 1'b1;
                        end
                        else
                        begin
                            s_gen      = 1'b1;
                            s_cmd.kind = CMD_LIT;
                            s_cmd.arg  = ARG_W'(field[7:0]);
                            s_prod     = produced_reg + 32'd1;
                            s_phase    = PH_FLAG;
                        end
                    end
                end
                PH_POS:
                begin
                    if (!have)
                    begin
                        s_end = 1'b1;
                    end
                    else
                    begin
                        s_cnt   = shamt;
                        s_mpos  = field[POS_BITS-1:0];
                        s_phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (!have)
                    begin
                        s_end = 1'b1;
                    end
                    else
                    begin
                        s_cnt = shamt;
                        if (copy_bad)
                        begin
                            s_fin  = 1'b1;
                            s_code = STS_BAD;
                            s_end  = 1'b1;
                        end
                        else
                        begin
                            s_gen      = 1'b1;
                            s_cmd.kind = CMD_COPY;
                            s_cmd.arg  = ARG_W'(match_pos_reg);
                            s_cmd.len  = LEN_W'(len_code);
                            s_prod     = produced_reg + 32'(len_full);
                            s_phase    = PH_FLAG;
                        end
                    end
                end
            endcase
        end

        stat_need = item_last_reg || (s_fin && !was_fin_reg);
        if (s_fin)
            stat_code = s_code;
        else if (s_phase != PH_FLAG)
            stat_code = STS_BAD;
        else
            stat_code = STS_SHORT;
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_buf_next   = bit_buf_reg;
        bit_cnt_next   = bit_cnt_reg;
        phase_next     = phase_reg;
        match_pos_next = match_pos_reg;
        produced_next  = produced_reg;
        limit_next     = limit_reg;
        finished_next  = finished_reg;
        end_code_next  = end_code_reg;
        item_last_next = item_last_reg;
        was_fin_next   = was_fin_reg;
        hold_vld_next  = hold_vld_reg;
        hold_cmd_next  = hold_cmd_reg;
        stat_next      = stat_reg;
        scode_next     = scode_reg;
        q_push         = 1'b0;
        q_wcmd         = hold_cmd_reg;

        if (cfg_we)
            limit_next = cfg_wdata;

        unique case (state_reg)
            FS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next     = FS_PARSE;
                    item_last_next = in_data.in_last;
                    was_fin_next   = finished_reg;
                    if (!finished_reg)
                    begin
                        bit_buf_next = {bit_buf_reg[BUF_W-9:0], in_data.in_byte};
                        bit_cnt_next = bit_cnt_reg + CNT_W'(8);
                    end
                end
            end
            FS_PARSE:
            begin
                if (!(s_gen && hold_vld_reg && q_full))
                begin
                    bit_cnt_next   = s_cnt;
                    phase_next     = s_phase;
                    match_pos_next = s_mpos;
                    produced_next  = s_prod;
                    finished_next  = s_fin;
                    end_code_next  = s_code;
                    if (s_gen)
                    begin
                        q_push        = hold_vld_reg;
                        hold_cmd_next = s_cmd;
                        hold_vld_next = 1'b1;
                    end
                    if (s_end)
                    begin
                        stat_next  = stat_need;
                        scode_next = stat_code;
                        if (hold_vld_reg)
                            state_next = FS_DRAIN;
                        else if (stat_need)
                            state_next = FS_STAT;
                        else
                            state_next = FS_IDLE;
                    end
                end
            end
            FS_DRAIN:
            begin
                if (!q_full)
                begin
                    q_push        = 1'b1;
                    q_wcmd.last   = !stat_reg;
                    hold_vld_next = 1'b0;
                    state_next    = stat_reg ? FS_STAT : FS_IDLE;
                end
            end
            FS_STAT:
            begin
                if (!q_full)
                begin
                    q_push         = 1'b1;
                    q_wcmd         = '0;
                    q_wcmd.kind    = CMD_STAT;
                    q_wcmd.code    = scode_reg;
                    q_wcmd.last    = 1'b1;
                    q_wcmd.restart = item_last_reg;
                    state_next     = FS_IDLE;
                    if (item_last_reg)
                    begin
                        bit_cnt_next  = '0;
                        phase_next    = PH_FLAG;
                        produced_next = '0;
                        finished_next = 1'b0;
                        end_code_next = STS_RUN;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            bit_cnt_reg   <= '0;
            phase_reg     <= PH_FLAG;
            produced_reg  <= '0;
            limit_reg     <= '0;
            finished_reg  <= 1'b0;
            end_code_reg  <= STS_RUN;
            item_last_reg <= 1'b0;
            was_fin_reg   <= 1'b0;
            hold_vld_reg  <= 1'b0;
            stat_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            produced_reg  <= produced_next;
            limit_reg     <= limit_next;
            finished_reg  <= finished_next;
            end_code_reg  <= end_code_next;
            item_last_reg <= item_last_next;
            was_fin_reg   <= was_fin_next;
            hold_vld_reg  <= hold_vld_next;
            stat_reg      <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_buf_reg   <= bit_buf_next;
        match_pos_reg <= match_pos_next;
        hold_cmd_reg  <= hold_cmd_next;
        scode_reg     <= scode_next;
    end

endmodule

FILE: hw/rtl/lzssdec_cmdq.sv
// Short command queue between the parser and the copy engine.
module lzssdec_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lzssdec_pkg::cmd_t wcmd,
    output logic              full,
    input  logic              pop,
    output lzssdec_pkg::cmd_t rcmd,
    output logic              empty
);
    import lzssdec_pkg::*;

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == (CMDQ_AW + 1)'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rcmd    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (CMDQ_AW + 1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (CMDQ_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wcmd;
    end

endmodule

FILE: hw/rtl/lzssdec_back.sv
// Back end: history window, match copy and the output register.
module lzssdec_back #(
    parameter int POS_BITS        = lzssdec_pkg::POS_BITS_DEF,
    parameter int LEN_BITS        = lzssdec_pkg::LEN_BITS_DEF,
    parameter int LOOKAHEAD_EXTRA = lzssdec_pkg::LOOKAHEAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  lzssdec_pkg::cmd_t q_cmd,
    output logic              q_pop,
    output lzssdec_pkg::out_t out_data,
    output logic              out_valid,
    input  logic              out_ready
);
    import lzssdec_pkg::*;

    localparam int WIN     = 1 << POS_BITS;
    localparam int LOOK    = (1 << LEN_BITS) + LOOKAHEAD_EXTRA;
    localparam int START_I = (WIN - (LOOK % WIN)) % WIN;
    localparam logic [POS_BITS-1:0] START = START_I[POS_BITS-1:0];

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_READ = 2'd1;
    localparam logic [1:0] BS_EMIT = 2'd2;

    logic [7:0]          win_mem [WIN];

    logic [1:0]          bstate_reg, bstate_next;
    logic [POS_BITS-1:0] wr_pos_reg, wr_pos_next;
    logic [POS_BITS:0]   fill_reg, fill_next, fill_inc;
    logic [POS_BITS-1:0] rd_pos_reg, rd_pos_next;
    logic [LEN_BITS:0]   left_reg, left_next;
    logic                cp_last_reg, cp_last_next;
    logic [7:0]          rd_data_reg;
    logic                rd_ok_reg;
    out_t                out_reg, out_next;
    logic                out_vld_reg, out_vld_next;

    logic                slot_free;
    logic                out_load;
    logic                mem_we;
    logic                mem_re;
    logic [7:0]          mem_wd;
    logic [POS_BITS-1:0] rd_off;
    logic                win_ok;
    logic [7:0]          copy_byte;

    assign out_data  = out_reg;
    assign out_valid = out_vld_reg;
    assign slot_free = !out_vld_reg || out_ready;
    assign fill_inc  = fill_reg[POS_BITS] ? fill_reg : fill_reg + (POS_BITS + 1)'(1);
    // entries outside the filled span are not cleared; reads of them return zero
    assign rd_off    = rd_pos_reg - START;
    assign win_ok    = fill_reg[POS_BITS] || ({1'b0, rd_off} < fill_reg);
    assign copy_byte = rd_ok_reg ? rd_data_reg : 8'd0;

    always_comb
    begin
        bstate_next  = bstate_reg;
        wr_pos_next  = wr_pos_reg;
        fill_next    = fill_reg;
        rd_pos_next  = rd_pos_reg;
        left_next    = left_reg;
        cp_last_next = cp_last_reg;
        out_next     = out_reg;
        out_load     = 1'b0;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wd       = copy_byte;

        unique case (bstate_reg)
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_cmd.kind)
                        CMD_LIT:
                        begin
                            if (slot_free)
                            begin
                                q_pop             = 1'b1;
                                mem_we            = 1'b1;
                                mem_wd            = q_cmd.arg[7:0];
                                out_load          = 1'b1;
                                out_next.out_byte = q_cmd.arg[7:0];
                                out_next.is_data  = 1'b1;
                                out_next.status   = STS_RUN;
                                out_next.run_last = q_cmd.last;
                                wr_pos_next       = wr_pos_reg + POS_BITS'(1);
                                fill_next         = fill_inc;
                            end
                        end
                        CMD_COPY:
                        begin
                            q_pop        = 1'b1;
                            rd_pos_next  = q_cmd.arg[POS_BITS-1:0];
                            left_next    = (LEN_BITS + 1)'(q_cmd.len[LEN_BITS-1:0])
                                           + (LEN_BITS + 1)'(2);
                            cp_last_next = q_cmd.last;
                            bstate_next  = BS_READ;
                        end
                        CMD_STAT:
                        begin
                            if (slot_free)
                            begin
                                q_pop             = 1'b1;
                                out_load          = 1'b1;
                                out_next.out_byte = 8'd0;
                                out_next.is_data  = 1'b0;
                                out_next.status   = q_cmd.code;
                                out_next.run_last = q_cmd.last;
                                if (q_cmd.restart)
                                begin
                                    wr_pos_next = START;
                                    fill_next   = '0;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_READ:
            begin
                mem_re      = 1'b1;
                bstate_next = BS_EMIT;
            end
            BS_EMIT:
            begin
                if (slot_free)
                begin
                    mem_we            = 1'b1;
                    out_load          = 1'b1;
                    out_next.out_byte = copy_byte;
                    out_next.is_data  = 1'b1;
                    out_next.status   = STS_RUN;
                    out_next.run_last = cp_last_reg && (left_reg == (LEN_BITS + 1)'(1));
                    wr_pos_next       = wr_pos_reg + POS_BITS'(1);
                    fill_next         = fill_inc;
                    rd_pos_next       = rd_pos_reg + POS_BITS'(1);
                    left_next         = left_reg - (LEN_BITS + 1)'(1);
                    if (left_reg == (LEN_BITS + 1)'(1))
                        bstate_next = BS_IDLE;
                    else
                        bstate_next = BS_READ;
                end
            end
            default:
            begin
                bstate_next = BS_IDLE;
            end
        endcase

        if (out_load)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg  <= BS_IDLE;
            wr_pos_reg  <= START;
            fill_reg    <= '0;
            left_reg    <= '0;
            cp_last_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            bstate_reg  <= bstate_next;
            wr_pos_reg  <= wr_pos_next;
            fill_reg    <= fill_next;
            left_reg    <= left_next;
            cp_last_reg <= cp_last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg <= rd_pos_next;
        out_reg    <= out_next;
        if (mem_we)
            win_mem[wr_pos_reg] <= mem_wd;
        if (mem_re)
        begin
            rd_data_reg <= win_mem[rd_pos_reg];
            rd_ok_reg   <= win_ok;
        end
    end

endmodule

FILE: hw/rtl/lzss_window256_decompressor_unit.sv
// Top level: LZSS decompressor, parser and copy engine joined by a command queue.
// Input: the next beat is taken only when the last is done (accept, one step per
// token field plus an end step, a drain push, a status push); a full queue stalls it.
// Output: a literal or status beat goes straight to the output register; a match
// alternates a window read with a write and emit per byte; a busy output stalls them.
// rst_n is asynchronous; the window reads as zeros by fill count, no clearing pass.
module lzss_window256_decompressor_unit #(
    parameter int POS_BITS        = lzssdec_pkg::POS_BITS_DEF,
    parameter int LEN_BITS        = lzssdec_pkg::LEN_BITS_DEF,
    parameter int LOOKAHEAD_EXTRA = lzssdec_pkg::LOOKAHEAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lzssdec_pkg::in_t  in_data,
    input  logic              in_valid,
    output logic              in_ready,
    output lzssdec_pkg::out_t out_data,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);
    import lzssdec_pkg::*;

    logic q_push;
    cmd_t q_wcmd;
    logic q_full;
    logic q_pop;
    cmd_t q_rcmd;
    logic q_empty;

    lzssdec_front #(
        .POS_BITS (POS_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_wcmd    (q_wcmd),
        .q_full    (q_full)
    );

    lzssdec_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wcmd  (q_wcmd),
        .full  (q_full),
        .pop   (q_pop),
        .rcmd  (q_rcmd),
        .empty (q_empty)
    );

    lzssdec_back #(
        .POS_BITS        (POS_BITS),
        .LEN_BITS        (LEN_BITS),
        .LOOKAHEAD_EXTRA (LOOKAHEAD_EXTRA)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_rcmd),
        .q_pop     (q_pop),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

FILE: hw/rtl/lzssdec_chk.sv
// Port-level checker for the decompressor, bound to the top level.
module lzssdec_chk (
    input logic              clk,
    input logic              rst_n,
    input lzssdec_pkg::in_t  in_data,
    input logic              in_valid,
    input logic              in_ready,
    input lzssdec_pkg::out_t out_data,
    input logic              out_valid,
    input logic              out_ready,
    input logic              cfg_we,
    input logic [31:0]       cfg_wdata
);
    import lzssdec_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_data |-> out_data.status == STS_RUN)
        else $error("data beat with non-running status");

    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_data |->
            out_data.run_last && out_data.out_byte == 8'd0 && out_data.status != STS_RUN)
        else $error("malformed status beat");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous beat still parsing");

endmodule

bind lzss_window256_decompressor_unit lzssdec_chk u_chk (.*);

FILE: bench/tb.sv
// Self-checking testbench for the LZSS 256-byte window decompressor: token streams in, bytes out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzssdec_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int N_RANDOM    = 480;
    localparam int SETTLE      = 20;
    localparam int STALL_LEN   = 400;
    localparam int WATCHDOG    = 3000;
    localparam int STALL_PHASE = 6;
    localparam int WIN_DEPTH   = 1 << POS_BITS_DEF;
    localparam logic [7:0] WP_START = 8'(WIN_DEPTH - (1 << LEN_BITS_DEF) - LOOKAHEAD_DEF);

    typedef enum logic [1:0] {TP_FLAG, TP_LIT, TP_POS, TP_LEN} tok_phase_e;
    typedef enum int {RDY_FULL, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} rdy_mode_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    in_t         in_data   = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    out_t        out_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;

    lzss_window256_decompressor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // decoder state
    logic [7:0]  win [WIN_DEPTH];
    logic [7:0]  win_wp;
    logic [31:0] bit_acc;
    int          bit_cnt;
    tok_phase_e  tok_phase;
    logic [7:0]  copy_pos;
    logic [31:0] n_produced;
    logic        stream_done;
    logic [1:0]  stop_code;
    logic [31:0] limit_reg = '0;

    out_t decoded_q[$];
    in_t  pend_q[$];
    in_t  stream_q[$];
    int   n_loaded = 0;
    int   n_errors = 0;

    // stream builder
    bit         gen_bits[$];
    int         gen_out;
    logic [7:0] gen_wp;

    // driver, monitor, watchdog
    int        gap_left   = 0;
    int        burst_left = 0;
    int        gap_sel;
    int        stall_req  = 0;
    int        stall_done = 0;
    int        stall_left = 0;
    int        mode_left  = 0;
    int        tick       = 0;
    rdy_mode_e rdy_mode   = RDY_FULL;
    logic      rdy;
    out_t      due_beat;
    int        idle_cycles = 0;

    function automatic void restart_stream();
        for (int i = 0; i < WIN_DEPTH; i++)
            win[i] = 8'd0;
        win_wp      = WP_START;
        bit_acc     = '0;
        bit_cnt     = 0;
        tok_phase   = TP_FLAG;
        copy_pos    = '0;
        n_produced  = '0;
        stream_done = 1'b0;
        stop_code   = STS_RUN;
    endfunction

    function automatic logic [7:0] pull_bits(int n);
        logic [31:0] v;
        v = (bit_acc >> (bit_cnt - n)) & ((32'd1 << n) - 32'd1);
        bit_cnt -= n;
        bit_acc &= (32'd1 << bit_cnt) - 32'd1;
        return v[7:0];
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        win[win_wp] = b;
        win_wp      = win_wp + 8'd1;
        n_produced  = n_produced + 32'd1;
        decoded_q.push_back('{out_byte: b, is_data: 1'b1, status: STS_RUN, run_last: 1'b0});
    endfunction

    function automatic void end_stream(logic [1:0] code);
        stream_done = 1'b1;
        stop_code   = code;
    endfunction

    function automatic void decode_byte(in_t beat);
        logic        was_done;
        logic        hold;
        logic [7:0]  v;
        logic [31:0] len;
        logic [1:0]  s;
        int          n_new;
        was_done = stream_done;
        hold     = 1'b0;
        n_new    = 0;
        if (!stream_done)
        begin
            bit_acc = {bit_acc[23:0], beat.in_byte};
            bit_cnt += 8;
            while (!stream_done && !hold)
            begin
                case (tok_phase)
                    TP_FLAG:
                    begin
                        if (n_produced >= limit_reg)
                            end_stream(STS_DONE);
                        else if (bit_cnt < 1)
                            hold = 1'b1;
                        else
                            tok_phase = (pull_bits(1) != 8'd0) ? TP_LIT : TP_POS;
                    end
                    TP_LIT:
                    begin
                        if (bit_cnt < 8)
                            hold = 1'b1;
                        else
                        begin
                            v = pull_bits(8);
                            if (n_produced >= limit_reg)
                                end_stream(STS_BAD);
                            else
                            begin
                                emit_byte(v);
                                n_new++;
                                tok_phase = TP_FLAG;
                            end
                        end
                    end
                    TP_POS:
                    begin
                        if (bit_cnt < POS_BITS_DEF)
                            hold = 1'b1;
                        else
                        begin
                            copy_pos  = pull_bits(POS_BITS_DEF);
                            tok_phase = TP_LEN;
                        end
                    end
                    default:
                    begin
                        if (bit_cnt < LEN_BITS_DEF)
                            hold = 1'b1;
                        else
                        begin
                            len = 32'(pull_bits(LEN_BITS_DEF)) + 32'd2;
                            if (n_produced >= limit_reg || limit_reg - n_produced < len)
                                end_stream(STS_BAD);
                            else
                            begin
                                for (int k = 0; k < len; k++)
                                begin
                                    emit_byte(win[8'(copy_pos + k)]);
                                    n_new++;
                                end
                                tok_phase = TP_FLAG;
                            end
                        end
                    end
                endcase
            end
        end
        if (beat.in_last || (stream_done && !was_done))
        begin
            if (stream_done)
                s = stop_code;
            else if (tok_phase != TP_FLAG)
                s = STS_BAD;
            else
                s = STS_SHORT;
            decoded_q.push_back('{out_byte: 8'd0, is_data: 1'b0, status: s, run_last: 1'b0});
            n_new++;
        end
        if (n_new > 0)
            decoded_q[decoded_q.size() - 1].run_last = 1'b1;
        if (beat.in_last)
            restart_stream();
    endfunction

    task automatic flag_mismatch(string what, logic [11:0] got_v, logic [11:0] due_v);
        $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got_v, due_v);
        n_errors++;
    endtask

    function automatic void push_raw(logic [7:0] b, logic last);
        stream_q.push_back('{in_byte: b, in_last: last});
    endfunction

    function automatic void gen_start();
        gen_bits.delete();
        gen_out = 0;
        gen_wp  = WP_START;
    endfunction

    function automatic void gen_field(logic [7:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            gen_bits.push_back(v[i]);
    endfunction

    function automatic void gen_lit(logic [7:0] v);
        gen_field(8'd1, 1);
        gen_field(v, 8);
        gen_out++;
        gen_wp = gen_wp + 8'd1;
    endfunction

    function automatic void gen_copy(logic [7:0] pos, logic [3:0] code);
        gen_field(8'd0, 1);
        gen_field(pos, POS_BITS_DEF);
        gen_field(8'(code), LEN_BITS_DEF);
        gen_out += int'(code) + 2;
        gen_wp = gen_wp + 8'(code) + 8'd2;
    endfunction

    function automatic void gen_token();
        logic [7:0] pos;
        logic [3:0] code;
        if ($urandom_range(0, 1) == 1)
            gen_lit(8'($urandom()));
        else
        begin
            if ($urandom_range(0, 9) < 7)
                pos = gen_wp - 8'($urandom_range(1, 24));
            else
                pos = 8'($urandom());
            code = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 4)) : 4'($urandom());
            gen_copy(pos, code);
        end
    endfunction

    // pad to a byte, optionally drop tail bytes or add trailing junk, mark the last beat
    function automatic void gen_pack(bit rand_pad, int drop, int extra);
        int         nb;
        logic [7:0] v;
        while (gen_bits.size() % 8 != 0)
            gen_bits.push_back(rand_pad ? 1'($urandom_range(0, 1)) : 1'b0);
        nb = gen_bits.size() / 8 - drop;
        if (nb < 1)
            nb = 1;
        for (int i = 0; i < nb; i++)
        begin
            v = 8'd0;
            for (int k = 0; k < 8; k++)
                v = {v[6:0], gen_bits[i * 8 + k]};
            push_raw(v, 1'b0);
        end
        repeat (extra)
            push_raw(8'($urandom()), 1'b0);
        stream_q[stream_q.size() - 1].in_last = 1'b1;
    endfunction

    task automatic build_stream(output int n_out);
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        gen_start();
        if (sel < 15)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                push_raw(8'($urandom()), i == n - 1);
            n_out = 0;
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                gen_token();
            gen_pack(1'($urandom_range(0, 1)), (sel < 30) ? $urandom_range(1, 2) : 0,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            n_out = gen_out;
        end
    endtask

    function automatic logic [31:0] pick_limit(int n_out);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return n_out;
        else if (sel < 55)
            return n_out + $urandom_range(1, 20);
        else if (sel < 70)
            return $urandom_range(0, n_out);
        else if (sel < 80)
            return 32'hFFFF_FFFF;
        else if (sel < 88)
            return 32'd0;
        else
            return $urandom();
    endfunction

    task automatic load();
        while (stream_q.size() > 0)
        begin
            pend_q.push_back(stream_q.pop_front());
            n_loaded++;
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pend_q.size() != 0 || in_valid || decoded_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_limit(logic [31:0] lim);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        limit_reg = lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    in_data  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 11);
                        gap_sel    = $urandom_range(0, 19);
                        if (gap_sel == 0)
                            gap_left = $urandom_range(10, 30);
                        else if (gap_sel < 7)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 5);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    flag_mismatch("beat with nothing expected", out_data, '0);
                else
                begin
                    due_beat = decoded_q.pop_front();
                    if (out_data.out_byte !== due_beat.out_byte)
                        flag_mismatch("out_byte", 12'(out_data.out_byte),
                                      12'(due_beat.out_byte));
                    if (out_data.is_data !== due_beat.is_data)
                        flag_mismatch("is_data", 12'(out_data.is_data),
                                      12'(due_beat.is_data));
                    if (out_data.status !== due_beat.status)
                        flag_mismatch("status", 12'(out_data.status),
                                      12'(due_beat.status));
                    if (out_data.run_last !== due_beat.run_last)
                        flag_mismatch("run_last", 12'(out_data.run_last),
                                      12'(due_beat.run_last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (stall_req != stall_done)
            begin
                stall_done++;
                stall_left = STALL_LEN - 1;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rdy_mode  = rdy_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                tick++;
                case (rdy_mode)
                    RDY_FULL:   rdy = 1'b1;
                    RDY_COIN:   rdy = 1'($urandom_range(0, 1));
                    RDY_SPARSE: rdy = (tick % 5 == 0);
                    default:    rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    // watchdog: no beat on either side while work is outstanding
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (pend_q.size() == 0 && !in_valid && decoded_q.size() == 0))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int   phase_no;
        int   n_str;
        int   n_goal;
        int   first_out;
        int   spare_out;
        in_t  held;

        restart_stream();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // limit at reset value zero: finish at once, ignore, then repeat the code on last
        push_raw(8'hFF, 1'b0);
        push_raw(8'h00, 1'b0);
        push_raw(8'h5A, 1'b1);
        load();
        wait_idle();

        // unbounded limit: overlapping copy of 17, ends on a token boundary; copy from 255
        write_limit(32'hFFFF_FFFF);
        gen_start();
        gen_lit(8'hFF);
        gen_lit(8'h00);
        gen_lit(8'hA5);
        gen_copy(WP_START, 4'hF);
        gen_pack(1'b0, 0, 0);
        gen_start();
        gen_lit(8'h3C);
        gen_copy(8'hFF, 4'h0);
        gen_pack(1'b1, 0, 0);
        load();
        wait_idle();

        // exact limit, then trailing input ignored
        write_limit(32'd5);
        gen_start();
        gen_lit(8'h11);
        gen_lit(8'h22);
        gen_copy(WP_START, 4'h1);
        gen_pack(1'b1, 0, 2);
        load();
        wait_idle();

        // copy that runs past the limit
        write_limit(32'd3);
        gen_start();
        gen_lit(8'h77);
        gen_copy(WP_START, 4'h3);
        gen_pack(1'b0, 0, 0);
        load();
        wait_idle();

        // limit lowered while a literal is half read
        write_limit(32'hFFFF_FFFF);
        gen_start();
        gen_lit(8'hC3);
        gen_lit(8'h96);
        gen_pack(1'b1, 0, 0);
        held = stream_q.pop_back();
        load();
        wait_idle();
        write_limit(32'd1);
        push_raw(held.in_byte, 1'b1);
        load();
        wait_idle();

        // zero limit on a single last beat
        write_limit(32'd0);
        push_raw(8'h80, 1'b1);
        load();

        n_goal   = n_loaded + N_RANDOM;
        phase_no = 0;
        while (n_loaded < n_goal)
        begin
            n_str = (phase_no == STALL_PHASE) ? 10 : $urandom_range(1, 4);
            build_stream(first_out);
            repeat (n_str - 1)
                build_stream(spare_out);
            if (phase_no != STALL_PHASE && $urandom_range(0, 3) == 0)
                load();
            else
            begin
                wait_idle();
                write_limit(pick_limit(first_out));
                if (phase_no == STALL_PHASE)
                    stall_req++;
                load();
            end
            phase_no++;
        end

        wait_idle();
        repeat (SETTLE) @(negedge clk);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
